FILE: design/rbt_pkg.sv
package rbt_pkg;

  // result symbol codes
  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_PLUS  = 2'd1;
  localparam logic [1:0] SYM_MINUS = 2'd2;
  localparam logic [1:0] SYM_POINT = 2'd3;

  // powers of three held in the table, and the index width
  localparam int NUM_POW = 40;
  localparam int PIDX_W  = 6;
  localparam int CNT_W   = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD,
    ST_DIV,
    ST_SCAN,
    ST_PREP,
    ST_DECIDE,
    ST_LEAD,
    ST_DIGITS,
    ST_POINT,
    ST_FAIL
  } rbt_state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_LEAD,
    EM_DIGIT,
    EM_POINT,
    EM_ERROR
  } emit_op_t;

  typedef struct packed {
    logic     take;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     scan_step;
    logic     prep;
    emit_op_t emit;
  } rbt_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic gcd_done;
    logic div_last;
    logic scan_last;
    logic fail;
    logic lead;
    logic ni_zero;
    logic nf_zero;
    logic pos_zero;
    logic pos_at_point;
    logic slot_free;
  } rbt_status_t;

  function automatic logic [63:0] pow3(input logic [PIDX_W-1:0] idx);
    logic [63:0] p;
    begin
      case (idx)
        6'd0:  p = 64'd1;
        6'd1:  p = 64'd3;
        6'd2:  p = 64'd9;
        6'd3:  p = 64'd27;
        6'd4:  p = 64'd81;
        6'd5:  p = 64'd243;
        6'd6:  p = 64'd729;
        6'd7:  p = 64'd2187;
        6'd8:  p = 64'd6561;
        6'd9:  p = 64'd19683;
        6'd10: p = 64'd59049;
        6'd11: p = 64'd177147;
        6'd12: p = 64'd531441;
        6'd13: p = 64'd1594323;
        6'd14: p = 64'd4782969;
        6'd15: p = 64'd14348907;
        6'd16: p = 64'd43046721;
        6'd17: p = 64'd129140163;
        6'd18: p = 64'd387420489;
        6'd19: p = 64'd1162261467;
        6'd20: p = 64'd3486784401;
        6'd21: p = 64'd10460353203;
        6'd22: p = 64'd31381059609;
        6'd23: p = 64'd94143178827;
        6'd24: p = 64'd282429536481;
        6'd25: p = 64'd847288609443;
        6'd26: p = 64'd2541865828329;
        6'd27: p = 64'd7625597484987;
        6'd28: p = 64'd22876792454961;
        6'd29: p = 64'd68630377364883;
        6'd30: p = 64'd205891132094649;
        6'd31: p = 64'd617673396283947;
        6'd32: p = 64'd1853020188851841;
        6'd33: p = 64'd5559060566555523;
        6'd34: p = 64'd16677181699666569;
        6'd35: p = 64'd50031545098999707;
        6'd36: p = 64'd150094635296999121;
        6'd37: p = 64'd450283905890997363;
        6'd38: p = 64'd1350851717672992089;
        6'd39: p = 64'd4052555153018976267;
        default: p = 64'd0;
      endcase
      return p;
    end
  endfunction

endpackage

FILE: design/rbt_in_if.sv
interface rbt_in_if #(parameter int VALUE_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] numerator;
  logic [VALUE_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink (input valid, input numerator, input denominator, output ready);
endinterface

FILE: design/rbt_out_if.sv
interface rbt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       last;
  logic       error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink (input valid, input symbol, input last, input error, output ready);
endinterface

FILE: design/rbt_ctrl.sv
module rbt_ctrl import rbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  rbt_status_t status,
  output rbt_cmd_t    cmd
);

  rbt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CHECK;
      ST_CHECK:  state_next = status.d_zero ? ST_FAIL : ST_GCD;
      ST_GCD:    if (status.gcd_done) state_next = ST_DIV;
      ST_DIV:    if (status.div_last) state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_last) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.fail) state_next = ST_FAIL;
        else if (status.lead) state_next = ST_LEAD;
        else state_next = ST_DIGITS;
      end
      ST_LEAD: begin
        if (status.slot_free) begin
          if (!status.ni_zero) state_next = ST_DIGITS;
          else if (!status.nf_zero) state_next = ST_POINT;
          else state_next = ST_IDLE;
        end
      end
      ST_DIGITS: begin
        if (status.slot_free) begin
          if (status.pos_zero) state_next = ST_IDLE;
          else if (status.pos_at_point) state_next = ST_POINT;
        end
      end
      ST_POINT:  if (status.slot_free) state_next = ST_DIGITS;
      ST_FAIL:   if (status.slot_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{take: 1'b0, gcd_step: 1'b0, div_init: 1'b0, div_step: 1'b0,
            scan_step: 1'b0, prep: 1'b0, emit: EM_NONE};
    unique case (state)
      ST_IDLE:   cmd.take = 1'b1;
      ST_CHECK:  ;
      ST_GCD: begin
        if (status.gcd_done) cmd.div_init = 1'b1;
        else cmd.gcd_step = 1'b1;
      end
      ST_DIV:    cmd.div_step = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_PREP:   cmd.prep = 1'b1;
      ST_DECIDE: ;
      ST_LEAD:   if (status.slot_free) cmd.emit = EM_LEAD;
      ST_DIGITS: if (status.slot_free) cmd.emit = EM_DIGIT;
      ST_POINT:  if (status.slot_free) cmd.emit = EM_POINT;
      ST_FAIL:   if (status.slot_free) cmd.emit = EM_ERROR;
      default:   ;
    endcase
  end

endmodule

FILE: design/rbt_datapath.sv
module rbt_datapath import rbt_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rbt_cmd_t               cmd,
  output rbt_status_t            status,
  input  logic                   in_valid,
  input  logic [VALUE_WIDTH-1:0] numerator,
  input  logic [VALUE_WIDTH-1:0] denominator,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             symbol,
  output logic                   last,
  output logic                   error
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = VW + 2;
  localparam int KW = $clog2(VW);

  function automatic logic [2*VW-1:0] div_iter(input logic [2*VW-1:0] acc,
                                               input logic [VW-1:0] d);
    logic [2*VW-1:0] t;
    begin
      t = {acc[2*VW-2:0], 1'b0};
      if (t[2*VW-1:VW] >= d) begin
        t[2*VW-1:VW] = t[2*VW-1:VW] - d;
        t[0] = 1'b1;
      end
      return t;
    end
  endfunction

  function automatic logic [1:0] swap_sign(input logic [1:0] s, input logic n);
    logic [1:0] r;
    begin
      r = s;
      if (n && s == SYM_PLUS) r = SYM_MINUS;
      else if (n && s == SYM_MINUS) r = SYM_PLUS;
      return r;
    end
  endfunction

  logic [VW-1:0]     mag_n, mag_d;
  logic [VW-1:0]     mn, md, u, v, g;
  logic [VW-1:0]     u_next, v_next;
  logic [KW-1:0]     k, k_next, dcnt;
  logic              neg;
  logic [2*VW-1:0]   acc_n, acc_d;
  logic [VW-1:0]     a, b;
  logic [PIDX_W-1:0] j, len, nf, lsz, ni, pos;
  logic [PIDX_W-1:0] l_c, ni_c;
  logic [SW-1:0]     sacc;
  logic              pow_fail, cnt_fail;
  logic [63:0]       pow_j, pow_lc, pow_nf, pow_l, pow_pos;
  logic [SW-1:0]     p_lc, half, p_l, pp, pp2, sub;
  logic              d0, e1, e2, total_fail;
  logic [CNT_W-1:0]  total;
  logic [1:0]        lead_sym, digit_sym;

  assign mag_n = numerator[VW-1] ? (~numerator + 1'b1) : numerator;
  assign mag_d = denominator[VW-1] ? (~denominator + 1'b1) : denominator;
  assign a = acc_n[VW-1:0];
  assign b = acc_d[VW-1:0];

  // one binary gcd step
  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + 1'b1;
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u >= v) begin
      u_next = (u - v) >> 1;
    end else begin
      v_next = (v - u) >> 1;
    end
  end

  // table lookups
  assign pow_j   = pow3(j);
  assign pow_lc  = pow3(l_c);
  assign pow_nf  = pow3(nf);
  assign pow_l   = pow3(lsz);
  assign pow_pos = pow3(pos);

  assign l_c  = (len > nf) ? len : nf;
  assign ni_c = (len > nf) ? (len - nf) : '0;
  assign p_lc = pow_lc[SW-1:0];
  assign half = (p_lc - 1'b1) >> 1;

  assign p_l  = pow_l[SW-1:0];
  assign d0   = sacc >= p_l;
  assign pp   = pow_pos[SW-1:0];
  assign pp2  = {pp[SW-2:0], 1'b0};
  assign e2   = sacc >= pp2;
  assign e1   = sacc >= pp;
  assign sub  = e2 ? pp2 : (e1 ? pp : '0);

  assign lead_sym  = d0 ? (neg ? SYM_MINUS : SYM_PLUS) : SYM_ZERO;
  assign digit_sym = swap_sign(e2 ? SYM_PLUS : (e1 ? SYM_ZERO : SYM_MINUS), neg);

  assign total = CNT_W'(status.lead) + CNT_W'(ni)
               + ((nf != '0) ? (CNT_W'(nf) + CNT_W'(1)) : '0);
  assign total_fail = total > CNT_W'(MAX_SYMBOLS);

  always_comb begin
    status.d_zero       = (v == '0);
    status.gcd_done     = (u == '0);
    status.div_last     = (dcnt == KW'(VW - 1));
    status.scan_last    = (j == PIDX_W'(NUM_POW - 1));
    status.lead         = d0 || (ni == '0);
    status.fail         = pow_fail || cnt_fail || total_fail;
    status.ni_zero      = (ni == '0);
    status.nf_zero      = (nf == '0);
    status.pos_zero     = (pos == '0);
    status.pos_at_point = (nf != '0) && (pos == nf);
    status.slot_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_valid) begin
      mn  <= mag_n;
      md  <= mag_d;
      u   <= mag_n;
      v   <= mag_d;
      k   <= '0;
      neg <= (mag_n != '0) && (numerator[VW-1] != denominator[VW-1]);
    end
    if (cmd.gcd_step) begin
      u <= u_next;
      v <= v_next;
      k <= k_next;
    end
    if (cmd.div_init) begin
      g     <= v << k;
      acc_n <= {{VW{1'b0}}, mn};
      acc_d <= {{VW{1'b0}}, md};
      dcnt  <= '0;
      j     <= '0;
      len   <= '0;
      nf    <= '0;
    end
    if (cmd.div_step) begin
      acc_n <= div_iter(acc_n, g);
      acc_d <= div_iter(acc_d, g);
      dcnt  <= dcnt + 1'b1;
    end
    if (cmd.scan_step) begin
      j <= j + 1'b1;
      if (pow_j < 64'(b)) nf <= j + 1'b1;
      if (pow_j <= 64'(a)) len <= j + 1'b1;
    end
    if (cmd.prep) begin
      lsz      <= l_c;
      ni       <= ni_c;
      pos      <= l_c - 1'b1;
      sacc     <= SW'(a) + half;
      pow_fail <= pow_nf != 64'(b);
      cnt_fail <= (CNT_W'(l_c) + CNT_W'(1)) > CNT_W'(MAX_SYMBOLS);
    end
    if (cmd.emit == EM_LEAD && d0) sacc <= sacc - p_l;
    if (cmd.emit == EM_DIGIT) begin
      sacc <= sacc - sub;
      pos  <= pos - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EM_LEAD: begin
        symbol <= lead_sym;
        last   <= (ni == '0) && (nf == '0);
        error  <= 1'b0;
      end
      EM_DIGIT: begin
        symbol <= digit_sym;
        last   <= (pos == '0);
        error  <= 1'b0;
      end
      EM_POINT: begin
        symbol <= SYM_POINT;
        last   <= 1'b0;
        error  <= 1'b0;
      end
      EM_ERROR: begin
        symbol <= SYM_ZERO;
        last   <= 1'b1;
        error  <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: design/rational_to_balanced_ternary.sv
// sequence: load, zero check, binary gcd steps, divide steps and the power-of-three scan, then
// one symbol per cycle while the sink takes every beat
// one fraction at a time: a new fraction waits until the previous one has emitted its last symbol
// the binary gcd loop and the two-lane restoring divider take most of the conversion time
// reset: synchronous active-high rst idles the controller and empties the result register
module rational_to_balanced_ternary import rbt_pkg::*; #(
  parameter int MAX_SYMBOLS = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  rbt_in_if.sink    frac,
  rbt_out_if.source trits
);

  // command and status between the sequencer and the datapath
  rbt_cmd_t    cmd;
  rbt_status_t status;

  // sequencer: load, zero check, gcd, divide by gcd, power-of-three scan, then symbol emission or an error beat
  rbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (frac.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: magnitudes, binary gcd, two-lane divider, balanced digit extraction
  // digits come out most significant first by comparing against powers of three
  // after the all-ones offset is added, so no carry pass is needed
  rbt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_valid    (frac.valid),
    .numerator   (frac.numerator),
    .denominator (frac.denominator),
    .out_ready   (trits.ready),
    .out_valid   (trits.valid),
    .symbol      (trits.symbol),
    .last        (trits.last),
    .error       (trits.error)
  );

  // input beat taken only while the sequencer is idle
  assign frac.ready = cmd.take;

  // an error beat closes its conversion
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    trits.valid && trits.error |-> trits.last)
    else $error("error beat without last");

  // an error beat carries the zero symbol
  a_err_sym: assert property (@(posedge clk) disable iff (rst)
    trits.valid && trits.error |-> trits.symbol == SYM_ZERO)
    else $error("error beat with nonzero symbol");

  // one conversion at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    frac.valid && frac.ready |=> !frac.ready)
    else $error("input taken twice in a row");

endmodule
